[hdl/xtime_pkg.sv]
// shared types and constants for the exclusive time calculator
package xtime_pkg;

	localparam int DEF_STACK_DEPTH = 32;

	localparam int TS_W      = 63;
	localparam int ELAPSED_W = 64;
	localparam int TAG_W     = 16;
	localparam int DEPTH_W   = 5;
	localparam int KIND_W    = 2;

	localparam int IN_TDATA_W  = 88;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 88;

	// input tdata layout
	localparam int IN_DEPTH_LSB = 0;
	localparam int IN_TS_LSB    = IN_DEPTH_LSB + DEPTH_W;
	localparam int IN_TAG_LSB   = IN_TS_LSB + TS_W;

	// input tuser layout
	localparam int IN_REQ_BIT   = 0;
	localparam int IN_NSTK_BIT  = 1;
	localparam int IN_ENTRY_BIT = 2;

	// output tdata layout
	localparam int OUT_TAG_LSB     = 0;
	localparam int OUT_DEPTH_LSB   = OUT_TAG_LSB + TAG_W;
	localparam int OUT_ELAPSED_LSB = OUT_DEPTH_LSB + DEPTH_W;
	localparam int OUT_USED_W      = OUT_ELAPSED_LSB + ELAPSED_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENTRY = 2'd0,
		KIND_EXIT  = 2'd1,
		KIND_TOTAL = 2'd2
	} xtime_kind_t;

	typedef struct packed {
		xtime_kind_t          kind;
		logic [TAG_W-1:0]     tag;
		logic [DEPTH_W-1:0]   depth;
		logic [ELAPSED_W-1:0] elapsed;
	} xtime_res_t;

	// slot store update from the compute stage
	typedef struct packed {
		logic                 en;
		logic                 entry;
		logic                 has_par;
		logic [TS_W-1:0]      ts;
		logic [ELAPSED_W-1:0] par_tally;
	} xtime_upd_t;

	// slot store read data seen by the compute stage
	typedef struct packed {
		logic [TS_W-1:0]      start;
		logic [ELAPSED_W-1:0] tally_cur;
		logic [ELAPSED_W-1:0] tally_par;
	} xtime_rd_t;

endpackage

[hdl/xtime_ram.sv]
// generic single write port ram with registered read
module xtime_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

[hdl/xtime_store.sv]
// per depth slot store: entry time and child tally rams, valid bits and write forwarding
module xtime_store #(
	parameter int STACK_DEPTH = xtime_pkg::DEF_STACK_DEPTH,
	parameter int SLOT_W      = $clog2(STACK_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [SLOT_W-1:0]      rd_slot,
	input  logic [SLOT_W-1:0]      rd_par,
	input  logic [SLOT_W-1:0]      cur_slot,
	input  logic [SLOT_W-1:0]      par_slot,
	input  xtime_pkg::xtime_upd_t  upd,
	output xtime_pkg::xtime_rd_t   rd
);

	logic [STACK_DEPTH-1:0] start_vld_q;
	logic [STACK_DEPTH-1:0] tally_vld_q;

	logic                            st_we;
	logic                            ta_we;
	logic [xtime_pkg::TS_W-1:0]      st_rdata;
	logic [xtime_pkg::ELAPSED_W-1:0] ta_cur_rdata;
	logic [xtime_pkg::ELAPSED_W-1:0] ta_par_rdata;

	logic                            fw_st_vld_q;
	logic [SLOT_W-1:0]               fw_st_addr_q;
	logic [xtime_pkg::TS_W-1:0]      fw_st_data_q;
	logic                            fw_ta_vld_q;
	logic [SLOT_W-1:0]               fw_ta_addr_q;
	logic [xtime_pkg::ELAPSED_W-1:0] fw_ta_data_q;

	assign st_we = upd.en && upd.entry;
	assign ta_we = upd.en && !upd.entry && upd.has_par;

	xtime_ram #(
		.WIDTH(xtime_pkg::TS_W),
		.DEPTH(STACK_DEPTH)
	) u_start_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(cur_slot),
		.wdata(upd.ts),
		.re   (rd_en),
		.raddr(rd_slot),
		.rdata(st_rdata)
	);

	xtime_ram #(
		.WIDTH(xtime_pkg::ELAPSED_W),
		.DEPTH(STACK_DEPTH)
	) u_tally_cur_ram (
		.clk  (clk),
		.we   (ta_we),
		.waddr(par_slot),
		.wdata(upd.par_tally),
		.re   (rd_en),
		.raddr(rd_slot),
		.rdata(ta_cur_rdata)
	);

	xtime_ram #(
		.WIDTH(xtime_pkg::ELAPSED_W),
		.DEPTH(STACK_DEPTH)
	) u_tally_par_ram (
		.clk  (clk),
		.we   (ta_we),
		.waddr(par_slot),
		.wdata(upd.par_tally),
		.re   (rd_en),
		.raddr(rd_par),
		.rdata(ta_par_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_vld_q <= '0;
			tally_vld_q <= '0;
			fw_st_vld_q <= 1'b0;
			fw_ta_vld_q <= 1'b0;
		end else begin
			if (upd.en) begin
				start_vld_q[cur_slot] <= upd.entry;
				tally_vld_q[cur_slot] <= 1'b0;
				if (!upd.entry && upd.has_par) begin
					tally_vld_q[par_slot] <= 1'b1;
				end
			end
			// writes landing on the same edge as a read are held and bypassed into its read data
			if (rd_en) begin
				fw_st_vld_q <= st_we;
				fw_ta_vld_q <= ta_we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fw_st_addr_q <= cur_slot;
			fw_st_data_q <= upd.ts;
			fw_ta_addr_q <= par_slot;
			fw_ta_data_q <= upd.par_tally;
		end
	end

	always_comb begin
		rd.start     = '0;
		rd.tally_cur = '0;
		rd.tally_par = '0;
		if (start_vld_q[cur_slot]) begin
			rd.start = (fw_st_vld_q && fw_st_addr_q == cur_slot) ? fw_st_data_q : st_rdata;
		end
		if (tally_vld_q[cur_slot]) begin
			rd.tally_cur = (fw_ta_vld_q && fw_ta_addr_q == cur_slot) ? fw_ta_data_q
				: ta_cur_rdata;
		end
		if (tally_vld_q[par_slot]) begin
			rd.tally_par = (fw_ta_vld_q && fw_ta_addr_q == par_slot) ? fw_ta_data_q
				: ta_par_rdata;
		end
	end

endmodule

[hdl/xtime_out_buf.sv]
// output register holding an optional stack total ahead of the record result
module xtime_out_buf (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_pre_vld,
	input  xtime_pkg::xtime_res_t               in_pre,
	input  xtime_pkg::xtime_res_t               in_main,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [xtime_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [xtime_pkg::KIND_W-1:0]        m_axis_tuser,
	output logic                                m_axis_tlast
);

	logic                  vld_q;
	logic                  pre_vld_q;
	xtime_pkg::xtime_res_t pre_q;
	xtime_pkg::xtime_res_t main_q;
	xtime_pkg::xtime_res_t cur;
	logic                  out_fire;

	assign out_fire = vld_q && m_axis_tready;
	assign in_ready = !vld_q || (m_axis_tready && !pre_vld_q);
	assign cur      = pre_vld_q ? pre_q : main_q;

	assign m_axis_tvalid = vld_q;
	assign m_axis_tlast  = !pre_vld_q;
	assign m_axis_tuser  = cur.kind;
	assign m_axis_tdata  = {
		(xtime_pkg::OUT_TDATA_W - xtime_pkg::OUT_USED_W)'(0),
		cur.elapsed,
		cur.depth,
		cur.tag
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			pre_vld_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				vld_q     <= 1'b1;
				pre_vld_q <= in_pre_vld;
			end else if (out_fire) begin
				if (pre_vld_q) begin
					pre_vld_q <= 1'b0;
				end else begin
					vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pre_q  <= in_pre;
			main_q <= in_main;
		end
	end

endmodule

[hdl/exclusive_time_from_call_trace_core.sv]
// top level of the exclusive time calculator for call trace records
// Accepts one trace transaction per cycle unless the output buffer stalls it.
// Each entry or exit record gives one result; a record that opens a new stack pass
// after an earlier one, gives first the stack total and then its own result. A finish
// request gives one stack total. The per-depth store sits in rams read at acceptance,
// with writes of the previous record bypassed into the compute stage, so back-to-back
// records on the same slots run at full rate. Per-slot valid flops clear the store at
// reset, so no clearing pass is needed.
module exclusive_time_from_call_trace_core #(
	parameter int STACK_DEPTH = xtime_pkg::DEF_STACK_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// depth, timestamp, func_id
	input  logic [xtime_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// req_type, new_stack, is_entry
	input  logic [xtime_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tag_out, depth_out, elapsed
	output logic [xtime_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// kind
	output logic [xtime_pkg::KIND_W-1:0]        m_axis_tuser,
	output logic                                m_axis_tlast
);

	localparam int SLOT_W = $clog2(STACK_DEPTH);

	logic [xtime_pkg::DEPTH_W-1:0] depth_in;
	logic [SLOT_W-1:0]             slot_in;
	logic [SLOT_W-1:0]             par_in;
	logic                          acc;
	logic                          adv;
	logic                          ob_ready;

	logic                            vld_s1;
	logic                            req_s1;
	logic                            nstk_s1;
	logic                            entry_s1;
	logic [xtime_pkg::DEPTH_W-1:0]   depth_s1;
	logic [SLOT_W-1:0]               slot_s1;
	logic [SLOT_W-1:0]               par_s1;
	logic [xtime_pkg::TS_W-1:0]      ts_s1;
	logic [xtime_pkg::TAG_W-1:0]     tag_s1;

	logic [xtime_pkg::TS_W-1:0]      stack_begin_q;
	logic [xtime_pkg::TS_W-1:0]      last_exit_q;

	xtime_pkg::xtime_rd_t            rd;
	xtime_pkg::xtime_upd_t           upd;
	xtime_pkg::xtime_res_t           pre_res;
	xtime_pkg::xtime_res_t           main_res;
	logic                            pre_vld;
	logic [xtime_pkg::ELAPSED_W-1:0] total;
	logic [xtime_pkg::ELAPSED_W-1:0] incl;
	logic [xtime_pkg::ELAPSED_W-1:0] excl;

	assign depth_in = s_axis_tdata[xtime_pkg::IN_DEPTH_LSB +: xtime_pkg::DEPTH_W];
	assign slot_in  = (32'(depth_in) >= STACK_DEPTH) ? SLOT_W'(STACK_DEPTH - 1)
		: SLOT_W'(depth_in);
	assign par_in   = slot_in - SLOT_W'(1);

	assign adv           = vld_s1 && ob_ready;
	assign s_axis_tready = !vld_s1 || ob_ready;
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			stack_begin_q <= '0;
			last_exit_q   <= '0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv && !req_s1) begin
				if (nstk_s1) begin
					stack_begin_q <= entry_s1 ? ts_s1 : '0;
				end
				if (!entry_s1) begin
					last_exit_q <= ts_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1   <= s_axis_tuser[xtime_pkg::IN_REQ_BIT];
			nstk_s1  <= s_axis_tuser[xtime_pkg::IN_NSTK_BIT];
			entry_s1 <= s_axis_tuser[xtime_pkg::IN_ENTRY_BIT];
			depth_s1 <= depth_in;
			slot_s1  <= slot_in;
			par_s1   <= par_in;
			ts_s1    <= s_axis_tdata[xtime_pkg::IN_TS_LSB +: xtime_pkg::TS_W];
			tag_s1   <= s_axis_tdata[xtime_pkg::IN_TAG_LSB +: xtime_pkg::TAG_W];
		end
	end

	assign total = {1'b0, last_exit_q} - {1'b0, stack_begin_q};
	assign incl  = {1'b0, ts_s1} - {1'b0, rd.start};
	assign excl  = incl - rd.tally_cur;

	assign upd.en        = adv && !req_s1;
	assign upd.entry     = entry_s1;
	assign upd.has_par   = slot_s1 != '0;
	assign upd.ts        = ts_s1;
	assign upd.par_tally = rd.tally_par + incl;

	xtime_store #(
		.STACK_DEPTH(STACK_DEPTH),
		.SLOT_W     (SLOT_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_slot (slot_in),
		.rd_par  (par_in),
		.cur_slot(slot_s1),
		.par_slot(par_s1),
		.upd     (upd),
		.rd      (rd)
	);

	always_comb begin
		pre_res.kind    = xtime_pkg::KIND_TOTAL;
		pre_res.tag     = '0;
		pre_res.depth   = '0;
		pre_res.elapsed = total;
		pre_vld         = !req_s1 && nstk_s1 && (stack_begin_q != '0);
		if (req_s1) begin
			main_res = pre_res;
		end else if (entry_s1) begin
			main_res.kind    = xtime_pkg::KIND_ENTRY;
			main_res.tag     = tag_s1;
			main_res.depth   = depth_s1;
			main_res.elapsed = '0;
		end else begin
			main_res.kind    = xtime_pkg::KIND_EXIT;
			main_res.tag     = tag_s1;
			main_res.depth   = depth_s1;
			main_res.elapsed = excl;
		end
	end

	xtime_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (vld_s1),
		.in_ready     (ob_ready),
		.in_pre_vld   (pre_vld),
		.in_pre       (pre_res),
		.in_main      (main_res),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
